[src/owl_pkg.sv]
// Shared types and constants for the ordered wait list.
// Used by owl_cell and ordered_wait_list; depends on nothing else.

package owl_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int SLOT_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int KEY_FIELD_W  = 32;

    localparam logic [1:0] KIND_INS_SORTED = 2'd0;
    localparam logic [1:0] KIND_INS_END    = 2'd1;
    localparam logic [1:0] KIND_REMOVE     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic                eval;
        logic [1:0]          kind;
        logic [SLOT_W-1:0]   slot;
        logic                ip_mark;
        logic [SLOT_W-1:0]   ip_slot;
        logic                ins;
        logic                rem;
    } cell_cmd_t;

endpackage

[src/owl_cell.sv]
// One position of the ordered wait list: a handle, its key and a valid bit.
// Depends on owl_pkg; instantiated in a row by ordered_wait_list.

module owl_cell #(
    parameter int KEY_BITS = owl_pkg::KEY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  owl_pkg::cell_cmd_t          cmd,
    input  logic [KEY_BITS-1:0]         req_key,
    input  logic                        mark_in,
    output logic                        mark_out,
    input  logic                        left_mark,
    output logic                        mark_q,
    input  logic                        left_valid,
    input  logic [owl_pkg::SLOT_W-1:0]  left_slot,
    input  logic [KEY_BITS-1:0]         left_key,
    input  logic                        right_valid,
    input  logic [owl_pkg::SLOT_W-1:0]  right_slot,
    input  logic [KEY_BITS-1:0]         right_key,
    output logic                        valid,
    output logic [owl_pkg::SLOT_W-1:0]  slot,
    output logic [KEY_BITS-1:0]         key,
    output logic                        hit
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [owl_pkg::SLOT_W-1:0]  slot_reg;
    logic [owl_pkg::SLOT_W-1:0]  slot_next;
    logic [KEY_BITS-1:0]         key_reg;
    logic [KEY_BITS-1:0]         key_next;
    logic                        mark_reg;
    logic                        mark_next;
    logic                        flag;

    // A cell is marked when it or any cell to its left meets the position test.
    always_comb
    begin
        hit = valid_reg && (slot_reg == cmd.slot);
        case (cmd.kind)
            owl_pkg::KIND_INS_SORTED: flag = !valid_reg || (key_reg > req_key);
            owl_pkg::KIND_INS_END:    flag = !valid_reg ||
                                             (!cmd.ip_mark && (slot_reg == cmd.ip_slot));
            owl_pkg::KIND_REMOVE:     flag = hit;
            default:                  flag = 1'b0;
        endcase
        mark_out  = mark_in || flag;
        mark_next = cmd.eval ? mark_out : mark_reg;
    end

    // Insert shifts marked cells right by one and drops the new entry into the
    // first marked cell; remove shifts marked cells left over the removed one.
    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        key_next   = key_reg;
        if (cmd.ins)
        begin
            if (left_mark)
            begin
                valid_next = left_valid;
                slot_next  = left_slot;
                key_next   = left_key;
            end
            else if (mark_reg)
            begin
                valid_next = 1'b1;
                slot_next  = cmd.slot;
                key_next   = req_key;
            end
        end
        else if (cmd.rem && mark_reg)
        begin
            valid_next = right_valid;
            slot_next  = right_slot;
            key_next   = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        key_reg  <= key_next;
    end

    assign mark_q = mark_reg;
    assign valid  = valid_reg;
    assign slot   = slot_reg;
    assign key    = key_reg;

endmodule

[src/ordered_wait_list.sv]
// Top level of the ordered wait list: controller, request registers and the cell row.
// Depends on owl_pkg and owl_cell.
//
//   channel   handshake             payload
//   request   in_valid / in_ready   kind, slot, sort_key
//   result    out_valid / out_ready item_count, status, head_slot, head_valid
//
// Each request passes through a compare state, in which every cell compares its
// entry against the request and the position marks ripple along the row, and a
// commit state, in which the row shifts. A new request is taken in the cycle the
// previous one commits, so requests follow without an idle state while results are taken.
// Reset empties the row at once. A result not yet taken holds the commit.

module ordered_wait_list #(
    parameter int SLOTS    = owl_pkg::SLOTS_DEF,
    parameter int KEY_BITS = owl_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [owl_pkg::SLOT_W-1:0]    slot,
    input  logic [owl_pkg::KEY_FIELD_W-1:0] sort_key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [owl_pkg::COUNT_W-1:0]   item_count,
    output logic                          status,
    output logic [owl_pkg::SLOT_W-1:0]    head_slot,
    output logic                          head_valid
);

    localparam int  HANDLES      = 1 << owl_pkg::SLOT_W;
    localparam int  NCELL        = (SLOTS < HANDLES) ? SLOTS : HANDLES;
    localparam bit  ALL_IN_RANGE = (SLOTS >= HANDLES);
    localparam logic [owl_pkg::SLOT_W:0] SLOT_LIMIT =
        ALL_IN_RANGE ? '0 : (owl_pkg::SLOT_W+1)'(SLOTS);

    owl_pkg::state_t                 state_reg;
    owl_pkg::state_t                 state_next;
    logic [1:0]                      kind_reg;
    logic [owl_pkg::SLOT_W-1:0]      slot_reg;
    logic [KEY_BITS-1:0]             key_reg;
    logic [KEY_BITS-1:0]             key_in;
    logic                            listed_reg;
    logic                            pred_valid_reg;
    logic [owl_pkg::SLOT_W-1:0]      pred_slot_reg;
    logic                            ip_mark_reg;
    logic                            ip_mark_next;
    logic [owl_pkg::SLOT_W-1:0]      ip_slot_reg;
    logic [owl_pkg::SLOT_W-1:0]      ip_slot_next;
    logic [owl_pkg::COUNT_W-1:0]     count_reg;
    logic [owl_pkg::COUNT_W-1:0]     count_next;
    logic                            status_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic                            in_fire;
    logic                            commit_go;
    logic                            in_range;
    logic                            is_insert;
    logic                            is_remove;
    logic                            ok;
    logic                            any_hit;
    logic                            pred_valid;
    logic [owl_pkg::SLOT_W-1:0]      pred_slot;
    owl_pkg::cell_cmd_t              cmd;

    logic [NCELL-1:0]                cell_valid;
    logic [owl_pkg::SLOT_W-1:0]      cell_slot [NCELL];
    logic [KEY_BITS-1:0]             cell_key  [NCELL];
    logic [NCELL-1:0]                cell_mark_q;
    logic [NCELL-1:0]                cell_hit;
    logic [NCELL:0]                  mark_chain;

    generate
        if (KEY_BITS <= owl_pkg::KEY_FIELD_W)
        begin : g_key_narrow
            assign key_in = sort_key[KEY_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign key_in = {{(KEY_BITS-owl_pkg::KEY_FIELD_W){1'b0}}, sort_key};
        end
    endgenerate

    always_comb
    begin
        commit_go  = (state_reg == owl_pkg::ST_COMMIT) && (!out_valid_reg || out_ready);
        in_ready   = (state_reg == owl_pkg::ST_IDLE) || commit_go;
        in_fire    = in_valid && in_ready;
        state_next = state_reg;
        case (state_reg)
            owl_pkg::ST_IDLE:
                if (in_fire)
                    state_next = owl_pkg::ST_EVAL;
            owl_pkg::ST_EVAL:
                state_next = owl_pkg::ST_COMMIT;
            owl_pkg::ST_COMMIT:
                if (commit_go)
                    state_next = in_fire ? owl_pkg::ST_EVAL : owl_pkg::ST_IDLE;
            default:
                state_next = owl_pkg::ST_IDLE;
        endcase
    end

    // Decision for the request under commit; the listed check comes from the
    // compare cycle.
    always_comb
    begin
        in_range  = ALL_IN_RANGE || ({1'b0, slot_reg} < SLOT_LIMIT);
        is_insert = kind_reg inside {owl_pkg::KIND_INS_SORTED, owl_pkg::KIND_INS_END};
        is_remove = (kind_reg == owl_pkg::KIND_REMOVE);
        if (is_insert)
            ok = in_range && !listed_reg;
        else if (is_remove)
            ok = in_range && listed_reg;
        else
            ok = 1'b1;

        cmd.eval    = (state_reg == owl_pkg::ST_EVAL);
        cmd.kind    = kind_reg;
        cmd.slot    = slot_reg;
        cmd.ip_mark = ip_mark_reg;
        cmd.ip_slot = ip_slot_reg;
        cmd.ins     = commit_go && is_insert && ok;
        cmd.rem     = commit_go && is_remove && ok;
    end

    // The removed entry's predecessor is whatever sits in the cell to its left.
    always_comb
    begin
        any_hit    = 1'b0;
        pred_valid = 1'b0;
        pred_slot  = '0;
        for (int i = 0; i < NCELL; i++)
        begin
            any_hit = any_hit | cell_hit[i];
            if (i > 0 && cell_hit[i])
            begin
                pred_valid = 1'b1;
                pred_slot  = pred_slot | cell_slot[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        ip_mark_next = ip_mark_reg;
        ip_slot_next = ip_slot_reg;
        if (cmd.ins)
            count_next = count_reg + 1'b1;
        if (cmd.rem)
        begin
            count_next = count_reg - 1'b1;
            if (!ip_mark_reg && (ip_slot_reg == slot_reg))
            begin
                ip_mark_next = !pred_valid_reg;
                ip_slot_next = pred_slot_reg;
            end
        end

        out_valid_next = out_valid_reg;
        if (commit_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= owl_pkg::ST_IDLE;
            ip_mark_reg   <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ip_mark_reg   <= ip_mark_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_slot_reg <= ip_slot_next;
        if (in_fire)
        begin
            kind_reg <= kind;
            slot_reg <= slot;
            key_reg  <= key_in;
        end
        if (cmd.eval)
        begin
            listed_reg     <= any_hit;
            pred_valid_reg <= pred_valid;
            pred_slot_reg  <= pred_slot;
        end
        if (commit_go)
            status_reg <= !ok;
    end

    assign mark_chain[0] = 1'b0;

    generate
        for (genvar i = 0; i < NCELL; i++)
        begin : g_cell
            logic                        l_mark;
            logic                        l_valid;
            logic [owl_pkg::SLOT_W-1:0]  l_slot;
            logic [KEY_BITS-1:0]         l_key;
            logic                        r_valid;
            logic [owl_pkg::SLOT_W-1:0]  r_slot;
            logic [KEY_BITS-1:0]         r_key;

            if (i == 0)
            begin : g_first
                assign l_mark  = 1'b0;
                assign l_valid = 1'b0;
                assign l_slot  = '0;
                assign l_key   = '0;
            end
            else
            begin : g_left
                assign l_mark  = cell_mark_q[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_slot  = cell_slot[i-1];
                assign l_key   = cell_key[i-1];
            end

            if (i == NCELL - 1)
            begin : g_last
                assign r_valid = 1'b0;
                assign r_slot  = '0;
                assign r_key   = '0;
            end
            else
            begin : g_right
                assign r_valid = cell_valid[i+1];
                assign r_slot  = cell_slot[i+1];
                assign r_key   = cell_key[i+1];
            end

            owl_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .req_key     (key_reg),
                .mark_in     (mark_chain[i]),
                .mark_out    (mark_chain[i+1]),
                .left_mark   (l_mark),
                .mark_q      (cell_mark_q[i]),
                .left_valid  (l_valid),
                .left_slot   (l_slot),
                .left_key    (l_key),
                .right_valid (r_valid),
                .right_slot  (r_slot),
                .right_key   (r_key),
                .valid       (cell_valid[i]),
                .slot        (cell_slot[i]),
                .key         (cell_key[i]),
                .hit         (cell_hit[i])
            );
        end
    endgenerate

    assign out_valid  = out_valid_reg;
    assign item_count = count_reg;
    assign status     = status_reg;
    assign head_valid = cell_valid[0];
    assign head_slot  = cell_valid[0] ? cell_slot[0] : '0;

    // The count always matches the occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(count_reg) == $countones(cell_valid)))
        else $error("item count differs from occupied cells");

    // Occupied cells are packed at the head end of the row.
    a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (((cell_valid + NCELL'(1)) & cell_valid) == '0))
        else $error("gap in occupied cells");

    // A rejected or ignored request leaves the row untouched.
    a_reject_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_go && !cmd.ins && !cmd.rem) |=> $stable(cell_valid) && $stable(count_reg))
        else $error("row changed on a request that was not applied");

    // The compare cycle is always followed by the commit cycle.
    a_eval_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == owl_pkg::ST_EVAL) |=> (state_reg == owl_pkg::ST_COMMIT))
        else $error("compare cycle not followed by commit");

endmodule

[sim/ordered_wait_list_tb.sv]
// Self-checking testbench for the ordered wait list: directed table, then random requests.
// Depends on owl_pkg and the ordered_wait_list top level; it carries its own list predictor.

module ordered_wait_list_tb;

    localparam int          SLOT_W          = owl_pkg::SLOT_W;
    localparam int          COUNT_W         = owl_pkg::COUNT_W;
    localparam int          KEY_FIELD_W     = owl_pkg::KEY_FIELD_W;
    localparam logic [1:0]  KIND_INS_SORTED = owl_pkg::KIND_INS_SORTED;
    localparam logic [1:0]  KIND_INS_END    = owl_pkg::KIND_INS_END;
    localparam logic [1:0]  KIND_REMOVE     = owl_pkg::KIND_REMOVE;
    localparam int          SLOTS        = owl_pkg::SLOTS_DEF;
    localparam logic [4:0]  END_MARK     = 5'(SLOTS);
    localparam logic [31:0] KEY_TAIL     = 32'hFFFF_FFFF;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 380;
    localparam int          HOLD_AT      = 120;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          BURST_ITEMS  = 30;
    localparam int          PAUSE_AT     = 260;
    localparam int          IDLE_LIMIT   = 500;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          PRINT_CAP    = 40;
    localparam int          ROWS         = 23;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic               status;
        logic [SLOT_W-1:0]  head;
        logic               head_ok;
    } result_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [SLOT_W-1:0]      slot;
        logic [KEY_FIELD_W-1:0] key;
        logic                   typed;
        result_t                exp_res;
    } stim_row_t;

    localparam result_t NO_RES = '0;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             kind;
    logic [SLOT_W-1:0]      slot;
    logic [KEY_FIELD_W-1:0] sort_key;
    logic                   out_valid;
    logic                   out_ready;
    logic [COUNT_W-1:0]     item_count;
    logic                   status;
    logic [SLOT_W-1:0]      head_slot;
    logic                   head_valid;

    // Predicted list state: index SLOTS is the end marker.
    logic [KEY_FIELD_W-1:0] wl_key    [0:SLOTS-1];
    logic [4:0]             wl_next   [0:SLOTS];
    logic [4:0]             wl_prev   [0:SLOTS];
    bit                     wl_listed [0:SLOTS-1];
    logic [4:0]             wl_ip;
    logic [4:0]             wl_total;

    result_t pending_results [$];

    int  errors        = 0;
    int  sent_count    = 0;
    int  results_seen  = 0;
    int  rejects_seen  = 0;
    int  peak_count    = 0;
    int  idle_cycles   = 0;
    bit  hold_req      = 0;

    // Rows with typed results are obvious from the list contents; the rest use the predictor.
    stim_row_t directed_rows [0:ROWS-1] = '{
        '{KIND_REMOVE,     4'd3,  32'd0,         1'b1, '{5'd0, 1'b1, 4'd0, 1'b0}},
        '{KIND_UNUSED,     4'd5,  32'd0,         1'b1, '{5'd0, 1'b0, 4'd0, 1'b0}},
        '{KIND_INS_SORTED, 4'd0,  32'd0,         1'b1, '{5'd1, 1'b0, 4'd0, 1'b1}},
        '{KIND_INS_SORTED, 4'd0,  32'd5,         1'b1, '{5'd1, 1'b1, 4'd0, 1'b1}},
        '{KIND_INS_SORTED, 4'd15, KEY_TAIL,      1'b1, '{5'd2, 1'b0, 4'd0, 1'b1}},
        '{KIND_INS_SORTED, 4'd7,  32'd100,       1'b0, NO_RES},
        '{KIND_INS_SORTED, 4'd8,  32'd100,       1'b0, NO_RES},
        '{KIND_INS_SORTED, 4'd9,  32'd0,         1'b0, NO_RES},
        '{KIND_INS_SORTED, 4'd12, 32'hFFFF_FFFE, 1'b0, NO_RES},
        '{KIND_INS_END,    4'd4,  32'd50,        1'b0, NO_RES},
        '{KIND_INS_END,    4'd4,  32'd1,         1'b0, NO_RES},
        '{KIND_REMOVE,     4'd0,  32'd0,         1'b0, NO_RES},
        '{KIND_REMOVE,     4'd0,  32'd0,         1'b0, NO_RES},
        '{KIND_INS_SORTED, 4'd2,  32'd0,         1'b0, NO_RES},
        '{KIND_INS_SORTED, 4'd3,  KEY_TAIL,      1'b0, NO_RES},
        '{KIND_INS_END,    4'd10, KEY_TAIL,      1'b0, NO_RES},
        '{KIND_UNUSED,     4'd15, KEY_TAIL,      1'b0, NO_RES},
        '{KIND_REMOVE,     4'd9,  32'd0,         1'b0, NO_RES},
        '{KIND_REMOVE,     4'd15, KEY_TAIL,      1'b0, NO_RES},
        '{KIND_REMOVE,     4'd10, 32'd0,         1'b0, NO_RES},
        '{KIND_INS_SORTED, 4'd5,  32'hAAAA_AAAA, 1'b0, NO_RES},
        '{KIND_INS_SORTED, 4'd6,  32'h5555_5555, 1'b0, NO_RES},
        '{KIND_INS_END,    4'd11, 32'h0000_FFFF, 1'b0, NO_RES}
    };

    ordered_wait_list dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .slot       (slot),
        .sort_key   (sort_key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .item_count (item_count),
        .status     (status),
        .head_slot  (head_slot),
        .head_valid (head_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
        errors++;
    endtask

    // Applies one request to the predicted list and returns the result it gives.
    task automatic predict_list_update(input logic [1:0] k, input logic [SLOT_W-1:0] s,
                                       input logic [KEY_FIELD_W-1:0] key,
                                       output result_t res);
        logic [4:0] at;
        logic [4:0] nx;
        logic [4:0] hd;
        bit         ok;
        bit         searching;
        int         steps;
        ok = 1'b1;
        if (k inside {KIND_INS_SORTED, KIND_INS_END})
        begin
            if (wl_listed[s])
                ok = 1'b0;
            else
            begin
                wl_key[s] = key;
                if (k == KIND_INS_END)
                    at = wl_prev[wl_ip];
                else if (key == KEY_TAIL)
                    at = wl_prev[END_MARK];
                else
                begin
                    // Walk past every entry whose key is not greater than the new one.
                    at = END_MARK;
                    searching = 1'b1;
                    steps = 0;
                    while (searching && steps < SLOTS)
                    begin
                        nx = wl_next[at];
                        if (nx == END_MARK || wl_key[nx[3:0]] > key)
                            searching = 1'b0;
                        else
                            at = nx;
                        steps++;
                    end
                end
                nx = wl_next[at];
                wl_next[s]  = nx;
                wl_prev[nx] = 5'(s);
                wl_prev[s]  = at;
                wl_next[at] = 5'(s);
                wl_listed[s] = 1'b1;
                wl_total++;
            end
        end
        else if (k == KIND_REMOVE)
        begin
            if (!wl_listed[s])
                ok = 1'b0;
            else
            begin
                at = wl_prev[s];
                nx = wl_next[s];
                wl_prev[nx] = at;
                wl_next[at] = nx;
                if (wl_ip == 5'(s))
                    wl_ip = at;
                wl_listed[s] = 1'b0;
                wl_total--;
            end
        end
        hd = wl_next[END_MARK];
        res.cnt     = wl_total;
        res.status  = !ok;
        res.head    = (hd != END_MARK) ? hd[3:0] : '0;
        res.head_ok = (hd != END_MARK);
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot(input bit want_listed);
        logic [SLOT_W-1:0] cands [$];
        int i;
        for (i = 0; i < SLOTS; i++)
            if (wl_listed[i] == want_listed)
                cands.push_back(SLOT_W'(i));
        if (cands.size() == 0)
            return SLOT_W'($urandom_range(0, SLOTS - 1));
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // Offers one request, waits for it to be taken, and queues the result it must produce.
    task automatic send_request(input logic [1:0] k, input logic [SLOT_W-1:0] s,
                                input logic [KEY_FIELD_W-1:0] key, input int gap,
                                input bit typed, input result_t typed_res);
        result_t predicted;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        slot     <= s;
        sort_key <= key;
        do @(posedge clk); while (!(in_valid && in_ready));
        predict_list_update(k, s, key, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
        sent_count++;
    endtask

    initial
    begin
        int                     i;
        int                     n;
        int                     r;
        int                     gap;
        int                     calm_left;
        int                     burst_left;
        bit                     calm;
        bit                     fill;
        logic [1:0]             k;
        logic [SLOT_W-1:0]      s;
        logic [KEY_FIELD_W-1:0] key;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = '0;
        slot      = '0;
        sort_key  = '0;
        out_ready = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            wl_key[i]    = '0;
            wl_next[i]   = '0;
            wl_prev[i]   = '0;
            wl_listed[i] = 1'b0;
        end
        wl_next[END_MARK] = END_MARK;
        wl_prev[END_MARK] = END_MARK;
        wl_ip             = END_MARK;
        wl_total          = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < ROWS; i++)
            send_request(directed_rows[i].kind, directed_rows[i].slot, directed_rows[i].key,
                         $urandom_range(0, 13), directed_rows[i].typed,
                         directed_rows[i].exp_res);

        calm_left  = 0;
        calm       = 1'b0;
        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(10, 30);
            end
            calm_left--;

            // The receiver stalls for a long stretch while requests keep coming back to back.
            if (n == HOLD_AT)
            begin
                hold_req   = 1'b1;
                burst_left = BURST_ITEMS;
            end
            if (n == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end

            // Alternate phases that favor inserts and removes so the list fills and drains.
            fill = ((n / 48) % 2 == 0);
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                k = KIND_UNUSED;
                s = SLOT_W'($urandom_range(0, SLOTS - 1));
            end
            else if (r < (fill ? 70 : 30))
            begin
                k = ($urandom_range(0, 2) == 0) ? KIND_INS_END : KIND_INS_SORTED;
                s = ($urandom_range(0, 9) < 8) ? pick_slot(1'b0)
                                               : SLOT_W'($urandom_range(0, SLOTS - 1));
            end
            else
            begin
                k = KIND_REMOVE;
                s = ($urandom_range(0, 9) < 8) ? pick_slot(1'b1)
                                               : SLOT_W'($urandom_range(0, SLOTS - 1));
            end

            // Small keys give many ties; the rest reach the extremes and the tail key.
            r = $urandom_range(0, 9);
            if (r < 4)
                key = KEY_FIELD_W'($urandom_range(0, 7));
            else if (r < 7)
                key = $urandom;
            else if (r == 7)
                key = KEY_TAIL;
            else if (r == 8)
                key = KEY_TAIL - 1;
            else
                key = '0;

            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
                gap = calm ? 0 : $urandom_range(0, 13);
            send_request(k, s, key, gap, 1'b0, NO_RES);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d results, %0d of them rejected",
                 sent_count, results_seen, rejects_seen);
        $display("list held at most %0d entries; %0d mismatches", peak_count, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, calm stretches, and one long hold on request.
    initial
    begin
        int stall;
        int calm_left;
        bit calm;
        calm_left = 0;
        calm      = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(10, 30);
            end
            calm_left--;
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request waiting, item_count",
                                longint'(item_count), -1);
            else
            begin
                want = pending_results.pop_front();
                if (item_count !== want.cnt)
                    report_mismatch("item_count", longint'(item_count), longint'(want.cnt));
                if (status !== want.status)
                    report_mismatch("status", longint'(status), longint'(want.status));
                if (head_slot !== want.head)
                    report_mismatch("head_slot", longint'(head_slot), longint'(want.head));
                if (head_valid !== want.head_ok)
                    report_mismatch("head_valid", longint'(head_valid),
                                    longint'(want.head_ok));
            end
            results_seen++;
            if (status === 1'b1)
                rejects_seen++;
            if (int'(item_count) > peak_count)
                peak_count = int'(item_count);
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no handshake for %0d cycles, giving up", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
